/* rtl/core/size_ordered_free_block_allocator_assert.svh */
// Assertion macros shared by the allocator RTL.
`ifndef SIZE_ORDERED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_ORDERED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SOA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("allocator assertion failed");
`define SOA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("allocator implication failed");
`define SOA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("allocator next-cycle check failed");
`else
`define SOA_ASSERT(label, prop)
`define SOA_ASSERT_IMP(label, ante, cons)
`define SOA_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/soa_pkg.sv */
// Types and constants of the size-ordered free block allocator.
`timescale 1ns / 1ps
package soa_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int ADDR_W = 20;
	localparam int SIZE_W = 21;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [SIZE_W-1:0] THRESHOLD_RESET = SIZE_W'(64);

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_TOO_BIG = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic OP_FREE = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t key;
	} cell_cmd_t;

	typedef struct packed {
		entry_t head;
		entry_t pick;
	} chain_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SPLIT,
		ST_DONE
	} fsm_state_t;

endpackage

/* rtl/core/soa_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface soa_req_if import soa_pkg::*; ();
	logic valid;
	logic ready;
	logic operation;
	logic [ADDR_W-1:0] block_address;
	logic [SIZE_W-1:0] block_size;

	modport source (output valid, operation, block_address, block_size, input ready);
	modport sink (input valid, operation, block_address, block_size, output ready);
endinterface

interface soa_rsp_if import soa_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [ADDR_W-1:0] granted_address;
	logic [SIZE_W-1:0] granted_size;
	logic [CNT_W-1:0] free_entries;

	modport source (output valid, status, granted_address, granted_size, free_entries,
		input ready);
	modport sink (input valid, status, granted_address, granted_size, free_entries,
		output ready);
endinterface

/* rtl/core/size_ordered_free_block_allocator.sv */
// Top level of the size-ordered free block allocator.
//
// channel  direction  fields
// req      in         operation, block_address, block_size
// rsp      out        status, granted_address, granted_size, free_entries
// cfg      in         cfg_data (split threshold), written when cfg_we is high
//
// A free passes from acceptance through the exec step to the done step, which loads the
// result; a granted allocate adds the split step between them. The sequencer drives one
// pass of the cell row per step (insert, or remove then reinsert of the leftover).
// Reset clears the block count and the sequencer; the cell contents need no clearing.
// While a result waits on rsp, the next word may still be accepted and worked;
// its result then holds in the done step until rsp frees up.
`timescale 1ns / 1ps
`include "size_ordered_free_block_allocator_assert.svh"
module size_ordered_free_block_allocator import soa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_data,
	soa_req_if.sink           req,
	soa_rsp_if.source         rsp
);

	fsm_state_t state_q, state_d;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] baddr_q;
	logic [SIZE_W-1:0] bsize_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SIZE_W-1:0] thr_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] gaddr_q;
	logic [SIZE_W-1:0] gsize_q;

	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [ADDR_W-1:0] rsp_addr_q;
	logic [SIZE_W-1:0] rsp_size_q;
	logic [CNT_W-1:0]  rsp_cnt_q;

	cell_cmd_t   cmd;
	chain_stat_t stat;
	logic [SIZE_W-1:0] left;
	logic do_split;
	logic is_full;
	logic is_empty;
	logic too_big;
	logic load_rsp;

	assign left = bsize_q - size_q;
	assign do_split = left >= thr_q;
	assign is_full = cnt_q == CNT_W'(TABLE_ENTRIES);
	assign is_empty = cnt_q == '0;
	assign too_big = size_q > stat.head.size;
	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	soa_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cnt    (cnt_q),
		.stat   (stat)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (op_q == OP_ALLOC && !is_empty && !too_big)
					state_d = ST_SPLIT;
				else
					state_d = ST_DONE;
			end
			ST_SPLIT: state_d = ST_DONE;
			ST_DONE: begin
				if (load_rsp)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		cmd.op = CELL_HOLD;
		cmd.key.size = size_q;
		cmd.key.addr = addr_q;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_EXEC: begin
				if (op_q == OP_FREE) begin
					if (!is_full)
						cmd.op = CELL_INSERT;
				end else if (!is_empty && !too_big) begin
					cmd.op = CELL_REMOVE;
				end
			end
			ST_SPLIT: begin
				cmd.key.size = left;
				cmd.key.addr = baddr_q + size_q[ADDR_W-1:0];
				if (do_split)
					cmd.op = CELL_INSERT;
			end
			default: begin
				req.ready = 1'b0;
				cmd.op = CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			thr_q <= THRESHOLD_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				thr_q <= cfg_data;
			if (cmd.op == CELL_INSERT)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (cmd.op == CELL_REMOVE)
				cnt_q <= cnt_q - CNT_W'(1);
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= req.operation;
				addr_q <= req.block_address;
				size_q <= req.block_size;
			end
			ST_EXEC: begin
				gaddr_q <= '0;
				gsize_q <= '0;
				baddr_q <= stat.pick.addr;
				bsize_q <= stat.pick.size;
				if (op_q == OP_FREE)
					status_q <= is_full ? STAT_FULL : STAT_OK;
				else if (is_empty)
					status_q <= STAT_EMPTY;
				else if (too_big)
					status_q <= STAT_TOO_BIG;
				else
					status_q <= STAT_OK;
			end
			ST_SPLIT: begin
				gaddr_q <= baddr_q;
				gsize_q <= do_split ? size_q : bsize_q;
			end
			ST_DONE: begin
				if (load_rsp) begin
					rsp_status_q <= status_q;
					rsp_addr_q <= gaddr_q;
					rsp_size_q <= gsize_q;
					rsp_cnt_q <= cnt_q;
				end
			end
			default: begin
				op_q <= op_q;
			end
		endcase
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.granted_address = rsp_addr_q;
	assign rsp.granted_size = rsp_size_q;
	assign rsp.free_entries = rsp_cnt_q;

	`SOA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(TABLE_ENTRIES))
	`SOA_ASSERT_NXT(a_cnt_quiet, state_q == ST_IDLE || state_q == ST_DONE, $stable(cnt_q))
	`SOA_ASSERT_IMP(a_err_zero, rsp.valid && rsp.status != STAT_OK,
		rsp.granted_address == '0 && rsp.granted_size == '0)

endmodule

/* rtl/core/soa_cell.sv */
// One table cell: holds a free block and shifts with its neighbors.
`timescale 1ns / 1ps
module soa_cell import soa_pkg::*; (
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      occ,
	input  logic      seed,
	input  logic      chain_in,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output logic      chain_out,
	output logic      eq,
	output logic      pick,
	output entry_t    entry
);

	entry_t entry_q;
	entry_t entry_d;
	logic ge;
	logic after;

	assign ge = !occ || (cmd.key.size >= entry_q.size);
	assign eq = occ && (cmd.key.size == entry_q.size);
	assign after = seed || chain_in || eq;
	assign chain_out = (cmd.op == CELL_INSERT) ? ge : after;
	assign pick = after && !chain_in;
	assign entry = entry_q;

	// On insert the cells from the slot onward move one place down; on remove
	// the cells from the picked slot onward pull up from their successor.
	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (chain_in)
					entry_d = prev_entry;
				else if (ge)
					entry_d = cmd.key;
			end
			CELL_REMOVE: begin
				if (after)
					entry_d = next_entry;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

/* rtl/core/soa_chain.sv */
// Row of table cells with the pick selection and the head tap.
`timescale 1ns / 1ps
`include "size_ordered_free_block_allocator_assert.svh"
module soa_chain import soa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] cnt,
	output chain_stat_t      stat
);

	entry_t entries [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] occ;
	logic [TABLE_ENTRIES-1:0] eq;
	logic [TABLE_ENTRIES-1:0] pick;
	logic [TABLE_ENTRIES:0] chain;
	logic no_match;

	// With no equal entry the head, the largest block, is taken.
	assign no_match = (cmd.op == CELL_REMOVE) && !(|eq);
	assign chain[0] = 1'b0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;

		assign occ[i] = CNT_W'(i) < cnt;
		if (i == 0) begin : g_first
			assign prev_e = entries[i];
		end else begin : g_mid
			assign prev_e = entries[i-1];
		end
		if (i == TABLE_ENTRIES - 1) begin : g_last
			assign next_e = entries[i];
		end else begin : g_rest
			assign next_e = entries[i+1];
		end

		soa_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ[i]),
			.seed       ((i == 0) ? no_match : 1'b0),
			.chain_in   (chain[i]),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.chain_out  (chain[i+1]),
			.eq         (eq[i]),
			.pick       (pick[i]),
			.entry      (entries[i])
		);
	end

	always_comb begin
		stat.head = entries[0];
		stat.pick = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			stat.pick.size = stat.pick.size | ({SIZE_W{pick[i]}} & entries[i].size);
			stat.pick.addr = stat.pick.addr | ({ADDR_W{pick[i]}} & entries[i].addr);
		end
	end

	// Held blocks stay in descending size order.
	for (genvar i = 0; i < TABLE_ENTRIES - 1; i++) begin : g_chk
		`SOA_ASSERT_IMP(a_sorted, occ[i+1], entries[i].size >= entries[i+1].size)
	end

endmodule
